@@ src/mlr_pkg.sv @@
// Shared opcode and control types for the midpoint line rasterizer.
package mlr_pkg;

    typedef enum logic {
        OP_START = 1'b0,
        OP_STEP  = 1'b1
    } opcode_t;

    // Per-cycle commands from the request stage to the line walker.
    typedef struct packed {
        logic load;
        logic step;
    } walk_ctl_t;

endpackage

@@ src/mlr_setup.sv @@
// Combinational line setup: axis choice, endpoint ordering and decision terms.
module mlr_setup #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0]        start_x,
    input  logic [COORD_BITS-1:0]        start_y,
    input  logic [COORD_BITS-1:0]        end_x,
    input  logic [COORD_BITS-1:0]        end_y,
    output logic                         steep,
    output logic                         minor_down,
    output logic                         line_valid,
    output logic [COORD_BITS-1:0]        major_pos,
    output logic [COORD_BITS-1:0]        minor_pos,
    output logic [COORD_BITS-1:0]        major_end,
    output logic signed [COORD_BITS+2:0] decision,
    output logic signed [COORD_BITS+2:0] minor_gain,
    output logic signed [COORD_BITS+2:0] flat_loss
);
    import mlr_pkg::*;

    localparam int DW = COORD_BITS + 3;

    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] major_len;
    logic [COORD_BITS-1:0] minor_len;
    logic [COORD_BITS-1:0] a_maj;
    logic [COORD_BITS-1:0] a_min;
    logic [COORD_BITS-1:0] b_maj;
    logic [COORD_BITS-1:0] b_min;
    logic                  swap;

    always_comb
    begin
        dx = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
        dy = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
        steep = (dy >= dx);
        if (steep)
        begin
            a_maj     = start_y;
            a_min     = start_x;
            b_maj     = end_y;
            b_min     = end_x;
            major_len = dy;
            minor_len = dx;
        end
        else
        begin
            a_maj     = start_x;
            a_min     = start_y;
            b_maj     = end_x;
            b_min     = end_y;
            major_len = dx;
            minor_len = dy;
        end

        // The walk always runs from the smaller major coordinate upward.
        swap = (b_maj < a_maj);
        major_pos  = swap ? b_maj : a_maj;
        minor_pos  = swap ? b_min : a_min;
        major_end  = swap ? a_maj : b_maj;
        minor_down = swap ? (a_min < b_min) : (b_min < a_min);
        line_valid = (major_len != '0);

        flat_loss  = DW'({minor_len, 1'b0});
        minor_gain = DW'({major_len - minor_len, 1'b0});
        decision   = $signed(DW'(major_len)) - flat_loss;
    end

endmodule

@@ src/mlr_core.sv @@
// Line walker: holds the current line and produces one pixel per step.
module mlr_core #(
    parameter int COORD_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mlr_pkg::walk_ctl_t      ctl,
    input  logic [COORD_BITS-1:0]   start_x,
    input  logic [COORD_BITS-1:0]   start_y,
    input  logic [COORD_BITS-1:0]   end_x,
    input  logic [COORD_BITS-1:0]   end_y,
    input  logic [31:0]             colour,
    output logic                    active,
    output logic [COORD_BITS-1:0]   pixel_x,
    output logic [COORD_BITS-1:0]   pixel_y,
    output logic [31:0]             pixel_colour,
    output logic                    last_pixel
);
    import mlr_pkg::*;

    localparam int DW = COORD_BITS + 3;

    logic                   set_steep;
    logic                   set_down;
    logic                   set_valid;
    logic [COORD_BITS-1:0]  set_major_pos;
    logic [COORD_BITS-1:0]  set_minor_pos;
    logic [COORD_BITS-1:0]  set_major_end;
    logic signed [DW-1:0]   set_decision;
    logic signed [DW-1:0]   set_gain;
    logic signed [DW-1:0]   set_loss;

    logic                   active_reg;
    logic                   active_next;
    logic                   steep_reg;
    logic                   steep_next;
    logic                   down_reg;
    logic                   down_next;
    logic [COORD_BITS-1:0]  major_pos_reg;
    logic [COORD_BITS-1:0]  major_pos_next;
    logic [COORD_BITS-1:0]  minor_pos_reg;
    logic [COORD_BITS-1:0]  minor_pos_next;
    logic [COORD_BITS-1:0]  major_end_reg;
    logic [COORD_BITS-1:0]  major_end_next;
    logic signed [DW-1:0]   decision_reg;
    logic signed [DW-1:0]   decision_next;
    logic signed [DW-1:0]   gain_reg;
    logic signed [DW-1:0]   gain_next;
    logic signed [DW-1:0]   loss_reg;
    logic signed [DW-1:0]   loss_next;
    logic [31:0]            colour_reg;
    logic [31:0]            colour_next;

    mlr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .steep      (set_steep),
        .minor_down (set_down),
        .line_valid (set_valid),
        .major_pos  (set_major_pos),
        .minor_pos  (set_minor_pos),
        .major_end  (set_major_end),
        .decision   (set_decision),
        .minor_gain (set_gain),
        .flat_loss  (set_loss)
    );

    assign active       = active_reg;
    assign pixel_x      = steep_reg ? minor_pos_reg : major_pos_reg;
    assign pixel_y      = steep_reg ? major_pos_reg : minor_pos_reg;
    assign pixel_colour = colour_reg;
    assign last_pixel   = (({1'b0, major_pos_reg} + 1'b1) == {1'b0, major_end_reg});

    always_comb
    begin
        active_next    = active_reg;
        steep_next     = steep_reg;
        down_next      = down_reg;
        major_pos_next = major_pos_reg;
        minor_pos_next = minor_pos_reg;
        major_end_next = major_end_reg;
        decision_next  = decision_reg;
        gain_next      = gain_reg;
        loss_next      = loss_reg;
        colour_next    = colour_reg;
        if (ctl.load)
        begin
            active_next    = set_valid;
            steep_next     = set_steep;
            down_next      = set_down;
            major_pos_next = set_major_pos;
            minor_pos_next = set_minor_pos;
            major_end_next = set_major_end;
            decision_next  = set_decision;
            gain_next      = set_gain;
            loss_next      = set_loss;
            colour_next    = colour;
        end
        else if (ctl.step && active_reg)
        begin
            // A negative decision means the midpoint lies past the line.
            if (decision_reg[DW-1])
            begin
                minor_pos_next = down_reg ? (minor_pos_reg - 1'b1) : (minor_pos_reg + 1'b1);
                decision_next  = decision_reg + gain_reg;
            end
            else
            begin
                decision_next = decision_reg - loss_reg;
            end
            major_pos_next = major_pos_reg + 1'b1;
            if (last_pixel)
            begin
                active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        steep_reg     <= steep_next;
        down_reg      <= down_next;
        major_pos_reg <= major_pos_next;
        minor_pos_reg <= minor_pos_next;
        major_end_reg <= major_end_next;
        decision_reg  <= decision_next;
        gain_reg      <= gain_next;
        loss_reg      <= loss_next;
        colour_reg    <= colour_next;
    end

endmodule

@@ src/midpoint_line_rasterizer_top.sv @@
// Top level of the midpoint line rasterizer: request register, walker, result register.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+------------------------------------------------
//   request | in_valid  | in_stall  | opcode, start_x, start_y, end_x, end_y, colour
//   result  | out_valid | out_stall | pixel_x, pixel_y, pixel_colour, last_pixel
//
// One request is taken per cycle while in_stall is low; a step request reaches the output
// through the request register and then the result register.
// The line setup and the per-pixel add and compare are each combinational between registers.
// Reset clears the request and result valids and drops any line in progress.
// While a result waits under out_stall, requests that yield no pixel still retire;
// a step request that would yield a pixel holds and in_stall rises.
module midpoint_line_rasterizer_top #(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  opcode,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    input  logic [31:0]           colour,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic [31:0]           pixel_colour,
    output logic                  last_pixel
);
    import mlr_pkg::*;

    logic                  req_valid_reg;
    logic                  req_valid_next;
    opcode_t               opcode_reg;
    logic [COORD_BITS-1:0] start_x_reg;
    logic [COORD_BITS-1:0] start_y_reg;
    logic [COORD_BITS-1:0] end_x_reg;
    logic [COORD_BITS-1:0] end_y_reg;
    logic [31:0]           colour_reg;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [COORD_BITS-1:0] pixel_x_reg;
    logic [COORD_BITS-1:0] pixel_y_reg;
    logic [31:0]           pixel_colour_reg;
    logic                  last_pixel_reg;

    logic                  accept;
    logic                  advance;
    logic                  emit;
    walk_ctl_t             ctl;
    logic                  walk_active;
    logic [COORD_BITS-1:0] walk_x;
    logic [COORD_BITS-1:0] walk_y;
    logic [31:0]           walk_colour;
    logic                  walk_last;

    assign emit    = req_valid_reg && (opcode_reg == OP_STEP) && walk_active;
    assign advance = req_valid_reg && (!emit || !out_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !advance;
    assign accept  = in_valid && !in_stall;

    assign ctl = '{load: advance && (opcode_reg == OP_START),
                   step: advance && (opcode_reg == OP_STEP)};

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg  <= opcode_t'(opcode);
            start_x_reg <= start_x;
            start_y_reg <= start_y;
            end_x_reg   <= end_x;
            end_y_reg   <= end_y;
            colour_reg  <= colour;
        end
        if (advance && emit)
        begin
            pixel_x_reg      <= walk_x;
            pixel_y_reg      <= walk_y;
            pixel_colour_reg <= walk_colour;
            last_pixel_reg   <= walk_last;
        end
    end

    mlr_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .start_x      (start_x_reg),
        .start_y      (start_y_reg),
        .end_x        (end_x_reg),
        .end_y        (end_y_reg),
        .colour       (colour_reg),
        .active       (walk_active),
        .pixel_x      (walk_x),
        .pixel_y      (walk_y),
        .pixel_colour (walk_colour),
        .last_pixel   (walk_last)
    );

    assign out_valid    = out_valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign pixel_colour = pixel_colour_reg;
    assign last_pixel   = last_pixel_reg;

endmodule
